// ===== src/tdq_pkg.sv =====
// ----------------------------------------------------------------------------
// tdq_pkg
// shared sizes, command codes, controller/datapath structs and helpers
// ----------------------------------------------------------------------------
package tdq_pkg;

    localparam int ENTRIES = 16;
    localparam int SLOTS   = 8;
    localparam int ENT_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // request command codes
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_ONCE   = 2'd1;
    localparam logic [1:0] CMD_PER    = 2'd2;
    localparam logic [1:0] CMD_CANCEL = 2'd3;

    // insert source select
    localparam logic [1:0] SRC_ONCE  = 2'd0;
    localparam logic [1:0] SRC_PER   = 2'd1;
    localparam logic [1:0] SRC_REARM = 2'd2;

    typedef struct packed {
        logic       latch;
        logic       adv_time;
        logic       pop;
        logic       scan_clr;
        logic       scan_next;
        logic       clr_slot;
        logic       alloc;
        logic       reject;
        logic       ins_load;
        logic [1:0] ins_src;
        logic       ins_shift;
        logic       ins_write;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       full;
        logic       head_due;
        logic       head_pid_nz;
        logic       slot_valid;
        logic       slot_match;
        logic       slot_last;
        logic       ins_later;
    } t_dp_stat;

    // deadline a strictly later than b, wrap aware
    function automatic logic later_than(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = b - a;
        return d[31];
    endfunction

endpackage

// ===== src/tdq_if.sv =====
// ----------------------------------------------------------------------------
// tdq request / response channels
// valid/ready channels carrying one request or one response
// ----------------------------------------------------------------------------
interface tdq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [23:0] delay;
    logic [15:0] payload;
    logic [15:0] cancel_id;

    modport source (output valid, cmd, delay, payload, cancel_id, input ready);
    modport sink   (input valid, cmd, delay, payload, cancel_id, output ready);
endinterface

interface tdq_rsp_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [15:0] new_id;
    logic        fired;
    logic [15:0] fired_payload;
    logic [15:0] fired_id;

    modport source (output valid, accepted, new_id, fired, fired_payload, fired_id,
                    input ready);
    modport sink   (input valid, accepted, new_id, fired, fired_payload, fired_id,
                     output ready);
endinterface

// ===== src/timer_deadline_queue.sv =====
// ----------------------------------------------------------------------------
// timer_deadline_queue
// deadline-ordered timer queue with one-shot and periodic entries
// ----------------------------------------------------------------------------
// One request in, one response out, one request at a time. A tick latches
// the request, advances the time by tick_step and checks the head entry; a
// due head is popped, and if it carries a periodic id the slot scan looks up
// that id and re-arms a matching entry through the insert walk, which moves
// each pending entry later than the new deadline one place toward the tail
// before the write. An accepted add takes the same insert walk (after the
// slot scan for a free slot on a periodic add); a cancel runs the slot scan.
// The insert walk moves one entry per cycle and the slot scan checks one slot
// per cycle. The response sits in an output register, and the next request
// is taken while it waits. tick_step sits at byte address 0 of the register
// port and resets to 1.
module timer_deadline_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tdq_req_if.sink     i_req,
    tdq_rsp_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    tdq_pkg::t_dp_cmd  w_cmd;
    tdq_pkg::t_dp_stat w_stat;
    logic [15:0]       r_tick_step;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, r_tick_step} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_step <= 16'd1;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_tick_step <= pwdata[15:0];
        end
    end

    tdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    tdq_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_tick_step     (r_tick_step),
        .i_req_cmd       (i_req.cmd),
        .i_delay         (i_req.delay),
        .i_payload       (i_req.payload),
        .i_cancel_id     (i_req.cancel_id),
        .o_accepted      (o_rsp.accepted),
        .o_new_id        (o_rsp.new_id),
        .o_fired         (o_rsp.fired),
        .o_fired_payload (o_rsp.fired_payload),
        .o_fired_id      (o_rsp.fired_id)
    );

    // no fire means empty fire fields
    a_nofire_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.fired) |-> (o_rsp.fired_payload == 16'd0 &&
                                           o_rsp.fired_id == 16'd0))
        else $error("fire fields set without a fire");

    // an id is only handed out by an accepted add
    a_id_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.new_id != 16'd0) |-> (o_rsp.accepted && !o_rsp.fired))
        else $error("new id on a rejected add or a tick");

    // one request at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while busy");

endmodule

// ===== src/tdq_dpath.sv =====
// ----------------------------------------------------------------------------
// tdq_dpath
// time counter, sorted pending store, periodic table and response registers
// ----------------------------------------------------------------------------
module tdq_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tdq_pkg::t_dp_cmd  i_cmd,
    output tdq_pkg::t_dp_stat o_stat,
    input  logic [15:0]       i_tick_step,
    input  logic [1:0]        i_req_cmd,
    input  logic [23:0]       i_delay,
    input  logic [15:0]       i_payload,
    input  logic [15:0]       i_cancel_id,
    output logic              o_accepted,
    output logic [15:0]       o_new_id,
    output logic              o_fired,
    output logic [15:0]       o_fired_payload,
    output logic [15:0]       o_fired_id
);

    logic [31:0]                 r_now;
    logic [tdq_pkg::CNT_W-1:0]   r_count;
    logic [15:0]                 r_next_id;
    logic [tdq_pkg::SLOTS-1:0]   r_pvalid;

    logic [31:0] r_dl   [tdq_pkg::ENTRIES];
    logic [15:0] r_pay  [tdq_pkg::ENTRIES];
    logic [15:0] r_pid  [tdq_pkg::ENTRIES];
    logic [15:0] r_tag  [tdq_pkg::SLOTS];
    logic [23:0] r_int  [tdq_pkg::SLOTS];
    logic [15:0] r_ppay [tdq_pkg::SLOTS];

    logic [1:0]                  r_cmd;
    logic [23:0]                 r_delay;
    logic [15:0]                 r_pay_in;
    logic [15:0]                 r_cid;
    logic [tdq_pkg::SLOT_W-1:0]  r_idx;
    logic [31:0]                 r_ins_dl;
    logic [15:0]                 r_ins_pay;
    logic [15:0]                 r_ins_pid;
    logic [tdq_pkg::CNT_W-1:0]   r_pos;
    logic                        r_acc;
    logic [15:0]                 r_nid;
    logic                        r_fired;
    logic [15:0]                 r_fpay;
    logic [15:0]                 r_fid;
    logic                        r_o_acc;
    logic [15:0]                 r_o_nid;
    logic                        r_o_fired;
    logic [15:0]                 r_o_fpay;
    logic [15:0]                 r_o_fid;

    logic [15:0]                 w_key;
    logic [15:0]                 w_id_inc;
    logic [15:0]                 w_id_new;
    logic [tdq_pkg::CNT_W-1:0]   w_pm1;
    logic [tdq_pkg::ENT_W-1:0]   w_pos_i;
    logic [tdq_pkg::ENT_W-1:0]   w_pm1_i;

    // scan key, fresh id and insert walk indexes
    assign w_key    = (r_cmd == tdq_pkg::CMD_TICK) ? r_fid : r_cid;
    assign w_id_inc = r_next_id + 16'd1;
    assign w_id_new = (w_id_inc == 16'd0) ? 16'd1 : w_id_inc;
    assign w_pm1    = r_pos - tdq_pkg::CNT_W'(1);
    assign w_pos_i  = r_pos[tdq_pkg::ENT_W-1:0];
    assign w_pm1_i  = w_pm1[tdq_pkg::ENT_W-1:0];

    // status to controller
    always_comb begin
        o_stat.cmd         = r_cmd;
        o_stat.full        = (r_count == tdq_pkg::CNT_W'(tdq_pkg::ENTRIES));
        o_stat.head_due    = (r_count != '0) && !tdq_pkg::later_than(r_dl[0], r_now);
        o_stat.head_pid_nz = (r_pid[0] != 16'd0);
        o_stat.slot_valid  = r_pvalid[r_idx];
        o_stat.slot_match  = r_pvalid[r_idx] && (r_tag[r_idx] == w_key) && (w_key != 16'd0);
        o_stat.slot_last   = (r_idx == tdq_pkg::SLOT_W'(tdq_pkg::SLOTS - 1));
        o_stat.ins_later   = (r_pos != '0) && tdq_pkg::later_than(r_dl[w_pm1_i], r_ins_dl);
    end

    // control state: time, fill count, id counter, slot valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now     <= '0;
            r_count   <= '0;
            r_next_id <= '0;
            r_pvalid  <= '0;
        end else begin
            if (i_cmd.adv_time) begin
                r_now <= r_now + {16'd0, i_tick_step};
            end
            if (i_cmd.pop) begin
                r_count <= r_count - tdq_pkg::CNT_W'(1);
            end else if (i_cmd.ins_write) begin
                r_count <= r_count + tdq_pkg::CNT_W'(1);
            end
            if (i_cmd.alloc) begin
                r_next_id       <= w_id_new;
                r_pvalid[r_idx] <= 1'b1;
            end else if (i_cmd.clr_slot) begin
                r_pvalid[r_idx] <= 1'b0;
            end
        end
    end

    // pending store: pop shifts toward head, insert walks from the tail
    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            for (int k = 0; k < tdq_pkg::ENTRIES - 1; k++) begin
                r_dl[k]  <= r_dl[k+1];
                r_pay[k] <= r_pay[k+1];
                r_pid[k] <= r_pid[k+1];
            end
        end else if (i_cmd.ins_shift) begin
            r_dl[w_pos_i]  <= r_dl[w_pm1_i];
            r_pay[w_pos_i] <= r_pay[w_pm1_i];
            r_pid[w_pos_i] <= r_pid[w_pm1_i];
        end else if (i_cmd.ins_write) begin
            r_dl[w_pos_i]  <= r_ins_dl;
            r_pay[w_pos_i] <= r_ins_pay;
            r_pid[w_pos_i] <= r_ins_pid;
        end
    end

    // periodic table payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc) begin
            r_tag[r_idx]  <= w_id_new;
            r_int[r_idx]  <= r_delay;
            r_ppay[r_idx] <= r_pay_in;
        end
    end

    // request latch, scan index, insert walk, working result
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd    <= i_req_cmd;
            r_delay  <= i_delay;
            r_pay_in <= i_payload;
            r_cid    <= i_cancel_id;
            r_acc    <= 1'b1;
            r_nid    <= 16'd0;
            r_fired  <= 1'b0;
            r_fpay   <= 16'd0;
            r_fid    <= 16'd0;
        end
        if (i_cmd.pop) begin
            r_fired <= 1'b1;
            r_fpay  <= r_pay[0];
            r_fid   <= r_pid[0];
        end
        if (i_cmd.reject) begin
            r_acc <= 1'b0;
        end
        if (i_cmd.alloc) begin
            r_nid <= w_id_new;
        end
        if (i_cmd.scan_clr) begin
            r_idx <= '0;
        end else if (i_cmd.scan_next) begin
            r_idx <= r_idx + tdq_pkg::SLOT_W'(1);
        end
        if (i_cmd.ins_load) begin
            r_pos <= r_count;
            case (i_cmd.ins_src)
                tdq_pkg::SRC_ONCE: begin
                    r_ins_dl  <= r_now + {8'd0, r_delay};
                    r_ins_pay <= r_pay_in;
                    r_ins_pid <= 16'd0;
                end
                tdq_pkg::SRC_PER: begin
                    r_ins_dl  <= r_now + {8'd0, r_delay};
                    r_ins_pay <= r_pay_in;
                    r_ins_pid <= w_id_new;
                end
                default: begin
                    r_ins_dl  <= r_now + {8'd0, r_int[r_idx]};
                    r_ins_pay <= r_ppay[r_idx];
                    r_ins_pid <= r_fid;
                end
            endcase
        end else if (i_cmd.ins_shift) begin
            r_pos <= w_pm1;
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_acc   <= r_acc;
            r_o_nid   <= r_nid;
            r_o_fired <= r_fired;
            r_o_fpay  <= r_fpay;
            r_o_fid   <= r_fid;
        end
    end

    assign o_accepted      = r_o_acc;
    assign o_new_id        = r_o_nid;
    assign o_fired         = r_o_fired;
    assign o_fired_payload = r_o_fpay;
    assign o_fired_id      = r_o_fid;

endmodule

// ===== src/tdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdq_ctrl
// sequencer for tick, add, cancel: slot scan and insert walk
// ----------------------------------------------------------------------------
module tdq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  tdq_pkg::t_dp_stat i_stat,
    output tdq_pkg::t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_ADV  = 3'd2;
    localparam logic [2:0] S_HEAD = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_INS  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.cmd)
                    tdq_pkg::CMD_TICK: begin
                        n_state = S_ADV;
                    end
                    tdq_pkg::CMD_ONCE: begin
                        if (i_stat.full) begin
                            o_cmd.reject = 1'b1;
                            n_state      = S_DONE;
                        end else begin
                            o_cmd.ins_load = 1'b1;
                            o_cmd.ins_src  = tdq_pkg::SRC_ONCE;
                            n_state        = S_INS;
                        end
                    end
                    tdq_pkg::CMD_PER: begin
                        if (i_stat.full) begin
                            o_cmd.reject = 1'b1;
                            n_state      = S_DONE;
                        end else begin
                            o_cmd.scan_clr = 1'b1;
                            n_state        = S_SCAN;
                        end
                    end
                    default: begin
                        o_cmd.scan_clr = 1'b1;
                        n_state        = S_SCAN;
                    end
                endcase
            end
            S_ADV: begin
                o_cmd.adv_time = 1'b1;
                n_state        = S_HEAD;
            end
            S_HEAD: begin
                if (i_stat.head_due) begin
                    o_cmd.pop      = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state        = i_stat.head_pid_nz ? S_SCAN : S_DONE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                case (i_stat.cmd)
                    tdq_pkg::CMD_TICK: begin
                        // re-arm a fired periodic entry still in the table
                        if (i_stat.slot_match) begin
                            o_cmd.ins_load = 1'b1;
                            o_cmd.ins_src  = tdq_pkg::SRC_REARM;
                            n_state        = S_INS;
                        end else if (i_stat.slot_last) begin
                            n_state = S_DONE;
                        end else begin
                            o_cmd.scan_next = 1'b1;
                        end
                    end
                    tdq_pkg::CMD_PER: begin
                        // first free slot
                        if (!i_stat.slot_valid) begin
                            o_cmd.alloc    = 1'b1;
                            o_cmd.ins_load = 1'b1;
                            o_cmd.ins_src  = tdq_pkg::SRC_PER;
                            n_state        = S_INS;
                        end else if (i_stat.slot_last) begin
                            o_cmd.reject = 1'b1;
                            n_state      = S_DONE;
                        end else begin
                            o_cmd.scan_next = 1'b1;
                        end
                    end
                    default: begin
                        // cancel clears every matching slot
                        o_cmd.clr_slot = i_stat.slot_match;
                        if (i_stat.slot_last) begin
                            n_state = S_DONE;
                        end else begin
                            o_cmd.scan_next = 1'b1;
                        end
                    end
                endcase
            end
            S_INS: begin
                if (i_stat.ins_later) begin
                    o_cmd.ins_shift = 1'b1;
                end else begin
                    o_cmd.ins_write = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // response valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== test/timer_deadline_queue_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timer_deadline_queue_test
// drives timer requests with random gaps, predicts every response from a
// behavioral model of the deadline queue and checks each response field
// ----------------------------------------------------------------------------
module timer_deadline_queue_test;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [23:0] delay;
        logic [15:0] payload;
        logic [15:0] cancel_id;
    } t_request;

    typedef struct packed {
        logic        accepted;
        logic [15:0] new_id;
        logic        fired;
        logic [15:0] fired_payload;
        logic [15:0] fired_id;
    } t_response;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tdq_req_if req_ch ();
    tdq_rsp_if rsp_ch ();

    timer_deadline_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // model state
    logic [15:0] step_ms;
    logic [31:0] clock_ms;
    logic [31:0] due_ms [tdq_pkg::ENTRIES];
    logic [15:0] due_pay [tdq_pkg::ENTRIES];
    logic [15:0] due_pid [tdq_pkg::ENTRIES];
    int          due_cnt;
    logic        per_used [tdq_pkg::SLOTS];
    logic [15:0] per_tag [tdq_pkg::SLOTS];
    logic [23:0] per_ival [tdq_pkg::SLOTS];
    logic [15:0] per_pay [tdq_pkg::SLOTS];
    logic [15:0] last_id;

    t_request  pending_reqs [$];
    t_response expected_rsps [$];
    int        errors;
    int        req_gap;
    int        rsp_gap;
    logic      feed_stall;
    logic      req_acc;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic logic is_later(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = b - a;
        return d[31];
    endfunction

    function automatic void model_reset();
        step_ms  = 16'd1;
        clock_ms = '0;
        due_cnt  = 0;
        last_id  = '0;
        for (int i = 0; i < tdq_pkg::SLOTS; i++) per_used[i] = 1'b0;
    endfunction

    function automatic void sorted_insert(logic [31:0] dl, logic [15:0] pay,
                                          logic [15:0] pid);
        int pos;
        pos = due_cnt;
        while (pos > 0 && is_later(due_ms[pos-1], dl)) begin
            due_ms[pos]  = due_ms[pos-1];
            due_pay[pos] = due_pay[pos-1];
            due_pid[pos] = due_pid[pos-1];
            pos--;
        end
        due_ms[pos]  = dl;
        due_pay[pos] = pay;
        due_pid[pos] = pid;
        due_cnt++;
    endfunction

    // timer queue response for one request, updating the model state
    function automatic t_response timer_response(t_request r);
        t_response o;
        int slot;
        logic [15:0] id;
        o = '0;
        o.accepted = 1'b1;
        case (r.cmd)
            tdq_pkg::CMD_TICK: begin
                clock_ms = clock_ms + step_ms;
                if (due_cnt > 0 && !is_later(due_ms[0], clock_ms)) begin
                    o.fired = 1'b1;
                    o.fired_payload = due_pay[0];
                    o.fired_id = due_pid[0];
                    for (int k = 1; k < due_cnt; k++) begin
                        due_ms[k-1]  = due_ms[k];
                        due_pay[k-1] = due_pay[k];
                        due_pid[k-1] = due_pid[k];
                    end
                    due_cnt--;
                    slot = -1;
                    if (o.fired_id != 16'd0)
                        for (int i = tdq_pkg::SLOTS - 1; i >= 0; i--)
                            if (per_used[i] && per_tag[i] == o.fired_id) slot = i;
                    if (slot >= 0 && due_cnt < tdq_pkg::ENTRIES)
                        sorted_insert(clock_ms + {8'd0, per_ival[slot]}, per_pay[slot],
                                      o.fired_id);
                end
            end
            tdq_pkg::CMD_ONCE: begin
                if (due_cnt < tdq_pkg::ENTRIES)
                    sorted_insert(clock_ms + {8'd0, r.delay}, r.payload, 16'd0);
                else o.accepted = 1'b0;
            end
            tdq_pkg::CMD_PER: begin
                slot = -1;
                for (int i = tdq_pkg::SLOTS - 1; i >= 0; i--) if (!per_used[i]) slot = i;
                if (slot < 0 || due_cnt >= tdq_pkg::ENTRIES) begin
                    o.accepted = 1'b0;
                end else begin
                    id = last_id + 16'd1;
                    if (id == 16'd0) id = 16'd1;
                    last_id = id;
                    per_used[slot] = 1'b1;
                    per_tag[slot]  = id;
                    per_ival[slot] = r.delay;
                    per_pay[slot]  = r.payload;
                    sorted_insert(clock_ms + {8'd0, r.delay}, r.payload, id);
                    o.new_id = id;
                end
            end
            default: begin
                if (r.cancel_id != 16'd0)
                    for (int i = 0; i < tdq_pkg::SLOTS; i++)
                        if (per_used[i] && per_tag[i] == r.cancel_id) per_used[i] = 1'b0;
            end
        endcase
        return o;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (req_ch.valid && !req_acc) begin
            // hold the request until it is taken
        end else if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0 && !feed_stall) begin
            t_request r;
            r = pending_reqs.pop_front();
            req_ch.valid     <= 1'b1;
            req_ch.cmd       <= r.cmd;
            req_ch.delay     <= r.delay;
            req_ch.payload   <= r.payload;
            req_ch.cancel_id <= r.cancel_id;
            req_gap <= pick_gap();
        end else begin
            req_ch.valid <= 1'b0;
        end
    end

    // response ready pattern
    always @(negedge i_clk) begin
        if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
            rsp_gap <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        end
    end

    // predict on accepted request, check on accepted response
    always @(posedge i_clk) begin
        req_acc <= i_rst_n && req_ch.valid && req_ch.ready;
        if (i_rst_n && req_ch.valid && req_ch.ready)
            expected_rsps.push_back(timer_response({req_ch.cmd, req_ch.delay,
                                                    req_ch.payload, req_ch.cancel_id}));
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0) begin
                $display("%0t: unexpected response", $time);
                errors++;
            end else begin
                t_response e;
                e = expected_rsps.pop_front();
                if (rsp_ch.accepted !== e.accepted) begin
                    $display("%0t: accepted exp %0d got %0d", $time, e.accepted,
                             rsp_ch.accepted);
                    errors++;
                end
                if (rsp_ch.new_id !== e.new_id) begin
                    $display("%0t: new_id exp %0d got %0d", $time, e.new_id,
                             rsp_ch.new_id);
                    errors++;
                end
                if (rsp_ch.fired !== e.fired) begin
                    $display("%0t: fired exp %0d got %0d", $time, e.fired, rsp_ch.fired);
                    errors++;
                end
                if (rsp_ch.fired_payload !== e.fired_payload) begin
                    $display("%0t: fired_payload exp %0d got %0d", $time,
                             e.fired_payload, rsp_ch.fired_payload);
                    errors++;
                end
                if (rsp_ch.fired_id !== e.fired_id) begin
                    $display("%0t: fired_id exp %0d got %0d", $time, e.fired_id,
                             rsp_ch.fired_id);
                    errors++;
                end
            end
        end
    end

    function automatic t_request make_req(logic [1:0] c, logic [23:0] d,
                                          logic [15:0] p, logic [15:0] x);
        t_request r;
        r.cmd = c;
        r.delay = d;
        r.payload = p;
        r.cancel_id = x;
        return r;
    endfunction

    // write tick_step while the queue is idle
    task automatic write_step(logic [15:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= '0;
        pwdata  <= {16'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        step_ms = v;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait until every request is sent and answered
    task automatic drain();
        while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // random phase: mostly adds and ticks with ids drawn from recent ones
    task automatic random_phase(int n, int tick_pct);
        logic [1:0]  c;
        logic [23:0] d;
        logic [15:0] x;
        logic [31:0] rnd;
        int          roll;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < tick_pct) c = tdq_pkg::CMD_TICK;
            else if (roll < tick_pct + (100 - tick_pct) / 3) c = tdq_pkg::CMD_ONCE;
            else if (roll < tick_pct + 2 * (100 - tick_pct) / 3) c = tdq_pkg::CMD_PER;
            else c = tdq_pkg::CMD_CANCEL;
            rnd = $urandom();
            case ($urandom_range(0, 5))
                0: d = rnd[23:0];
                1: d = 24'hFFFFFF;
                2: d = 24'd0;
                default: d = 24'(rnd[5:0] % 41);
            endcase
            rnd = $urandom();
            if ($urandom_range(0, 4) == 0) x = rnd[15:0];
            else x = last_id - {12'd0, rnd[19:16] % 4'd10};
            rnd = $urandom();
            pending_reqs.push_back(make_req(c, d, rnd[15:0], x));
        end
    endtask

    initial begin
        errors     = 0;
        req_gap    = 0;
        rsp_gap    = 0;
        feed_stall = 1'b0;
        i_rst_n    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        req_ch.valid     = 1'b0;
        req_ch.cmd       = tdq_pkg::CMD_TICK;
        req_ch.delay     = '0;
        req_ch.payload   = '0;
        req_ch.cancel_id = '0;
        rsp_ch.ready     = 1'b0;
        model_reset();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: zero delay, extremes, periodic, cancel, unknown cancel
        pending_reqs.push_back(make_req(tdq_pkg::CMD_TICK, 24'd0, 16'd0, 16'd0));
        pending_reqs.push_back(make_req(tdq_pkg::CMD_ONCE, 24'd0, 16'hFFFF, 16'd0));
        pending_reqs.push_back(make_req(tdq_pkg::CMD_ONCE, 24'hFFFFFF, 16'h0001, 16'hFFFF));
        pending_reqs.push_back(make_req(tdq_pkg::CMD_TICK, 24'hFFFFFF, 16'hFFFF, 16'hFFFF));
        pending_reqs.push_back(make_req(tdq_pkg::CMD_PER, 24'd1, 16'hA5A5, 16'd0));
        pending_reqs.push_back(make_req(tdq_pkg::CMD_PER, 24'd0, 16'h5A5A, 16'd0));
        pending_reqs.push_back(make_req(tdq_pkg::CMD_TICK, 24'd0, 16'd0, 16'd0));
        pending_reqs.push_back(make_req(tdq_pkg::CMD_TICK, 24'd0, 16'd0, 16'd0));
        pending_reqs.push_back(make_req(tdq_pkg::CMD_CANCEL, 24'd0, 16'd0, 16'd1));
        pending_reqs.push_back(make_req(tdq_pkg::CMD_CANCEL, 24'd0, 16'd0, 16'd0));
        pending_reqs.push_back(make_req(tdq_pkg::CMD_CANCEL, 24'd0, 16'd0, 16'hFFFF));
        pending_reqs.push_back(make_req(tdq_pkg::CMD_TICK, 24'd0, 16'd0, 16'd0));
        pending_reqs.push_back(make_req(tdq_pkg::CMD_TICK, 24'd0, 16'd0, 16'd0));
        // fill the periodic table and the pending store
        for (int i = 0; i < 10; i++)
            pending_reqs.push_back(make_req(tdq_pkg::CMD_PER, 24'd5 + 24'(i), 16'(i),
                                            16'd0));
        for (int i = 0; i < 10; i++)
            pending_reqs.push_back(make_req(tdq_pkg::CMD_ONCE, 24'd3, 16'h100 + 16'(i),
                                            16'd0));
        drain();

        // tick_step extremes, including zero and the largest step
        write_step(16'd0);
        random_phase(200, 50);
        drain();
        write_step(16'hFFFF);
        random_phase(250, 40);
        drain();
        write_step(16'd1);
        random_phase(300, 45);
        drain();
        write_step(16'd7);
        random_phase(250, 55);
        drain();
        // plain ticks to pop due entries from the store, then a mixed phase
        write_step(16'd3);
        for (int i = 0; i < 50; i++)
            pending_reqs.push_back(make_req(tdq_pkg::CMD_TICK, 24'd0, 16'd0, 16'd0));
        random_phase(250, 50);
        drain();

        if (errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

    initial begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
